[src/xe_pkg.sv]
`timescale 1ns / 1ps
// Shared types, character constants and entity tables for the XML entity escaper.
package xe_pkg;

	localparam int CODE_W = 16;

	// configuration register indexes
	localparam logic REG_ATTRIBUTE_MODE = 1'b0;
	localparam logic REG_NUMERIC_ESCAPE = 1'b1;

	localparam logic [CODE_W-1:0] C_TAB   = 16'h0009;
	localparam logic [CODE_W-1:0] C_LF    = 16'h000A;
	localparam logic [CODE_W-1:0] C_CR    = 16'h000D;
	localparam logic [CODE_W-1:0] C_QUOT  = 16'h0022;
	localparam logic [CODE_W-1:0] C_AMP   = 16'h0026;
	localparam logic [CODE_W-1:0] C_APOS  = 16'h0027;
	localparam logic [CODE_W-1:0] C_DASH  = 16'h002D;
	localparam logic [CODE_W-1:0] C_LT    = 16'h003C;
	localparam logic [CODE_W-1:0] C_GT    = 16'h003E;
	localparam logic [CODE_W-1:0] C_SPACE = 16'd32;
	localparam logic [CODE_W-1:0] C_DEL   = 16'd127;

	localparam logic [7:0] B_AMP  = 8'h26;
	localparam logic [7:0] B_HASH = 8'h23;
	localparam logic [7:0] B_SEMI = 8'h3B;
	localparam logic [7:0] B_ZERO = 8'h30;

	// fixed entities, left aligned in eight bytes
	localparam logic [63:0] S_AMP  = {"&amp;",  24'h0};
	localparam logic [63:0] S_LT   = {"&lt;",   32'h0};
	localparam logic [63:0] S_GT   = {"&gt;",   32'h0};
	localparam logic [63:0] S_QUOT = {"&quot;", 16'h0};
	localparam logic [63:0] S_APOS = {"&apos;", 16'h0};
	localparam logic [63:0] S_DASH = {"&#45;",  24'h0};

	typedef enum logic [2:0] {
		K_PLAIN,
		K_AMP,
		K_LT,
		K_GT,
		K_QUOT,
		K_APOS,
		K_DASH,
		K_NUM
	} kind_t;

	// classification of one request
	typedef struct packed {
		kind_t      kind;
		logic [3:0] len;   // bytes in the run, 1..8
		logic [2:0] pidx;  // power of ten of the leading digit
	} cls_t;

	// d * 10^p for p in 0..4, d in 1..9
	localparam logic [16:0] STEP [0:4][1:9] = '{
		'{17'd1,     17'd2,     17'd3,     17'd4,     17'd5,
		  17'd6,     17'd7,     17'd8,     17'd9},
		'{17'd10,    17'd20,    17'd30,    17'd40,    17'd50,
		  17'd60,    17'd70,    17'd80,    17'd90},
		'{17'd100,   17'd200,   17'd300,   17'd400,   17'd500,
		  17'd600,   17'd700,   17'd800,   17'd900},
		'{17'd1000,  17'd2000,  17'd3000,  17'd4000,  17'd5000,
		  17'd6000,  17'd7000,  17'd8000,  17'd9000},
		'{17'd10000, 17'd20000, 17'd30000, 17'd40000, 17'd50000,
		  17'd60000, 17'd70000, 17'd80000, 17'd90000}
	};

	function automatic logic [7:0] pick_byte(input logic [63:0] s, input logic [2:0] idx);
		logic [5:0] sh;
		sh = {3'd7 - idx, 3'b000};
		return s[sh +: 8];
	endfunction

	// byte idx of a fixed entity
	function automatic logic [7:0] entity_byte(input kind_t k, input logic [2:0] idx);
		logic [7:0] b;
		case (k)
			K_AMP:   b = pick_byte(S_AMP, idx);
			K_LT:    b = pick_byte(S_LT, idx);
			K_GT:    b = pick_byte(S_GT, idx);
			K_QUOT:  b = pick_byte(S_QUOT, idx);
			K_APOS:  b = pick_byte(S_APOS, idx);
			K_DASH:  b = pick_byte(S_DASH, idx);
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

[src/xe_in_if.sv]
`timescale 1ns / 1ps
// Character request channel: valid, ready and one character code.
interface xe_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] char_code;
	logic        string_end;

	modport source (output valid, output char_code, output string_end, input ready);
	modport sink (input valid, input char_code, input string_end, output ready);
endinterface

[src/xe_out_if.sv]
`timescale 1ns / 1ps
// Escaped byte channel: valid, ready and one output byte with run markers.
interface xe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_last;

	modport source (output valid, output out_byte, output run_last, output string_last,
		input ready);
	modport sink (input valid, input out_byte, input run_last, input string_last,
		output ready);
endinterface

[src/xe_classify.sv]
`timescale 1ns / 1ps
// Decides the escape form, run length and leading digit of one character.
module xe_classify (
	input  logic [15:0]  code,
	input  logic         last,
	input  logic         attr_mode,
	input  logic         num_en,
	input  logic         prev_dash,
	input  logic         at_start,
	output xe_pkg::cls_t cls
);
	import xe_pkg::*;

	logic       is_num;
	logic [2:0] nd;

	assign is_num = num_en && code != C_TAB && code != C_LF && code != C_CR
		&& (code < C_SPACE || code > C_DEL);

	always_comb begin
		if (code >= 16'd10000) nd = 3'd5;
		else if (code >= 16'd1000) nd = 3'd4;
		else if (code >= 16'd100) nd = 3'd3;
		else if (code >= 16'd10) nd = 3'd2;
		else nd = 3'd1;
	end

	always_comb begin
		cls.pidx = nd - 3'd1;
		if (code == C_AMP) begin
			cls.kind = K_AMP;
			cls.len  = 4'd5;
		end else if (code == C_LT) begin
			cls.kind = K_LT;
			cls.len  = 4'd4;
		end else if (code == C_GT) begin
			cls.kind = K_GT;
			cls.len  = 4'd4;
		end else if (attr_mode && code == C_QUOT) begin
			cls.kind = K_QUOT;
			cls.len  = 4'd6;
		end else if (attr_mode && code == C_APOS) begin
			cls.kind = K_APOS;
			cls.len  = 4'd6;
		end else if (!attr_mode && code == C_DASH) begin
			if (at_start || last || prev_dash) begin
				cls.kind = K_DASH;
				cls.len  = 4'd5;
			end else begin
				cls.kind = K_PLAIN;
				cls.len  = 4'd1;
			end
		end else if (is_num) begin
			cls.kind = K_NUM;
			cls.len  = {1'b0, nd} + 4'd3;
		end else begin
			cls.kind = K_PLAIN;
			cls.len  = 4'd1;
		end
	end

endmodule

[src/xml_entity_escape.sv]
`timescale 1ns / 1ps
// Top level of the XML entity escaper.
//
// char_ch takes one character code per request with a string_end flag.
// byte_ch returns the escaped text one byte per request; run_last marks the
// last byte of each character and string_last the last byte of a string.
// The configuration port writes attribute_mode (index 0) and numeric_escape
// (index 1) on any edge with cfg_we high; write only while idle.
// A character is loaded into the run register on acceptance and its bytes
// leave through the output register one per cycle while byte_ch does not
// stall. A character of n bytes holds the run register until all n have
// moved on: plain characters sustain one per cycle unstalled, entities are
// 4 to 6 bytes and decimal references 4 to 8, one digit per unstalled cycle
// from a compare-subtract against powers of ten. The next character is
// taken in the cycle its predecessor's last byte moves to the output.
// A stalled byte_ch holds the output register and, once the run register
// is full, char_ch ready drops. Reset empties both registers, sets
// attribute_mode 0, numeric_escape 1 and starts a new string.
module xml_entity_escape (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic          cfg_wdata,
	xe_in_if.sink         char_ch,
	xe_out_if.source      byte_ch
);
	import xe_pkg::*;

	logic        attr_mode_q;
	logic        num_en_q;
	logic        prev_dash_q;
	logic        at_start_q;

	logic        busy_q;
	kind_t       kind_q;
	logic [3:0]  len_q;
	logic [2:0]  idx_q;
	logic [2:0]  pidx_q;
	logic [15:0] rem_q;
	logic        last_q;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        run_last_q;
	logic        string_last_q;

	cls_t        cls;
	logic        accept;
	logic        advance;
	logic        last_byte;
	logic        is_digit;
	logic [3:0]  digit;
	logic [16:0] sub;
	logic [7:0]  cur_byte;

	xe_classify u_classify (
		.code      (char_ch.char_code),
		.last      (char_ch.string_end),
		.attr_mode (attr_mode_q),
		.num_en    (num_en_q),
		.prev_dash (prev_dash_q),
		.at_start  (at_start_q),
		.cls       (cls)
	);

	assign advance   = busy_q && (!out_valid_q || byte_ch.ready);
	assign last_byte = ({1'b0, idx_q} == len_q - 4'd1);
	assign char_ch.ready = !busy_q || (advance && last_byte);
	assign accept    = char_ch.valid && char_ch.ready;
	assign is_digit  = (kind_q == K_NUM) && (idx_q >= 3'd2) && !last_byte;

	// leading decimal digit of rem_q at power pidx_q
	always_comb begin
		digit = 4'd0;
		sub   = 17'd0;
		if (pidx_q <= 3'd4) begin
			for (int d = 1; d <= 9; d++) begin
				if ({1'b0, rem_q} >= STEP[pidx_q][d]) begin
					digit = 4'(d);
					sub   = STEP[pidx_q][d];
				end
			end
		end
	end

	always_comb begin
		case (kind_q)
			K_PLAIN: cur_byte = rem_q[7:0];
			K_NUM: begin
				if (idx_q == 3'd0) cur_byte = B_AMP;
				else if (idx_q == 3'd1) cur_byte = B_HASH;
				else if (last_byte) cur_byte = B_SEMI;
				else cur_byte = B_ZERO + {4'd0, digit};
			end
			default: cur_byte = entity_byte(kind_q, idx_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_mode_q <= 1'b0;
			num_en_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ATTRIBUTE_MODE: attr_mode_q <= cfg_wdata;
				REG_NUMERIC_ESCAPE: num_en_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_dash_q <= 1'b0;
			at_start_q  <= 1'b1;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				prev_dash_q <= !char_ch.string_end && (char_ch.char_code == C_DASH);
				at_start_q  <= char_ch.string_end;
				busy_q      <= 1'b1;
			end else if (advance && last_byte) begin
				busy_q <= 1'b0;
			end
			if (advance) out_valid_q <= 1'b1;
			else if (byte_ch.ready) out_valid_q <= 1'b0;
		end
	end

	// run register and output register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= cls.kind;
			len_q  <= cls.len;
			pidx_q <= cls.pidx;
			idx_q  <= 3'd0;
			rem_q  <= char_ch.char_code;
			last_q <= char_ch.string_end;
		end else if (advance) begin
			idx_q <= idx_q + 3'd1;
			if (is_digit) begin
				rem_q <= rem_q - sub[15:0];
				if (pidx_q != 3'd0) pidx_q <= pidx_q - 3'd1;
			end
		end
		if (advance) begin
			out_byte_q    <= cur_byte;
			run_last_q    <= last_byte;
			string_last_q <= last_byte && last_q;
		end
	end

	assign byte_ch.valid       = out_valid_q;
	assign byte_ch.out_byte    = out_byte_q;
	assign byte_ch.run_last    = run_last_q;
	assign byte_ch.string_last = string_last_q;

`ifndef NO_ASSERTIONS
	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ({1'b0, idx_q} < len_q))
		else $error("run index past run length");

	a_num_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && kind_q == K_NUM && last_byte |-> rem_q == 16'd0)
		else $error("decimal reference closed with digits left");

	a_plain_len: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && kind_q == K_PLAIN |-> len_q == 4'd1)
		else $error("plain character with multi-byte run");

	a_str_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && string_last_q |-> run_last_q)
		else $error("string end off a run boundary");
`endif

endmodule
